[sv/iou_pkg.sv]
// shared types, widths and codes for the best-match iou scorer
package iou_pkg;

  localparam int MAX_TRUTH  = 16;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int CMD_W     = 2;
  localparam int ST_W      = 2;
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int IOU_W     = FRAC_BITS + 1;
  localparam int SUM_W     = 8 + FRAC_BITS;
  localparam int SUMX_W    = SUM_W + 1;
  localparam int CNT_W     = $clog2(MAX_TRUTH + 1);
  localparam int IDX_W     = (MAX_TRUTH > 1) ? $clog2(MAX_TRUTH) : 1;
  localparam int AREA_W    = 2 * COORD_BITS;
  localparam int UNI_W     = AREA_W + 1;
  localparam int REM_W     = UNI_W + 1;
  localparam int DCNT_W    = $clog2(IOU_W);
  localparam int CMP_W     = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;

  localparam logic [REG_W-1:0]     IMG_RESET = REG_W'(4096);
  localparam logic [IOU_W-1:0]     IOU_ONE   = IOU_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]     CNT_MAX   = CNT_W'(MAX_TRUTH);
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SCORE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_OVL,
    S_MUL,
    S_UNION,
    S_DIV,
    S_CMP,
    S_ACCUM,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } box_t;

  typedef struct packed {
    logic    take_item;
    logic    set_status;
    status_t status_code;
    logic    store_box;
    logic    clear_all;
    logic    start_score;
    logic    fetch;
    logic    overlap;
    logic    mult;
    logic    div_init;
    logic    div_step;
    logic    compare;
    logic    accumulate;
    logic    publish;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             box_fits;
    logic             table_full;
    logic             table_empty;
    logic             last_entry;
    logic             div_last;
    logic             out_free;
  } dp_stat_t;

endpackage

[sv/iou_in_if.sv]
// input channel: command and box beat
interface iou_in_if;
  import iou_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_w;
  logic [COORD_BITS-1:0] box_h;

  modport source (output valid, command, box_x, box_y, box_w, box_h, input ready);
  modport sink (input valid, command, box_x, box_y, box_w, box_h, output ready);
endinterface

[sv/iou_out_if.sv]
// result channel: status, best iou, running sum and table count
interface iou_out_if;
  import iou_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IOU_W-1:0] best_iou;
  logic [SUM_W-1:0] iou_sum;
  logic [CNT_W-1:0] truth_count;

  modport source (output valid, status, best_iou, iou_sum, truth_count, input ready);
  modport sink (input valid, status, best_iou, iou_sum, truth_count, output ready);
endinterface

[sv/iou_cfg_if.sv]
// configuration write channel
interface iou_cfg_if;
  import iou_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/iou_dp.sv]
// datapath: truth table, overlap, multiply, serial divider, best and sum
module iou_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  iou_pkg::dp_cmd_t           cmd,
  output iou_pkg::dp_stat_t          stat,
  input  logic [iou_pkg::CMD_W-1:0]  item_command,
  input  iou_pkg::box_t              item_box,
  input  logic                       cfg_we,
  input  logic [iou_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iou_pkg::REG_W-1:0]  cfg_data,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [iou_pkg::ST_W-1:0]   out_status,
  output logic [iou_pkg::IOU_W-1:0]  out_best_iou,
  output logic [iou_pkg::SUM_W-1:0]  out_iou_sum,
  output logic [iou_pkg::CNT_W-1:0]  out_truth_count
);
  import iou_pkg::*;

  function automatic logic [COORD_BITS-1:0] span(
    input logic [COORD_BITS-1:0] a0,
    input logic [COORD_BITS-1:0] aw,
    input logic [COORD_BITS-1:0] b0,
    input logic [COORD_BITS-1:0] bw
  );
    logic [COORD_BITS:0] lo;
    logic [COORD_BITS:0] ae;
    logic [COORD_BITS:0] be;
    logic [COORD_BITS:0] hi;
    logic [COORD_BITS:0] d;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ae = {1'b0, a0} + {1'b0, aw};
    be = {1'b0, b0} + {1'b0, bw};
    hi = (ae < be) ? ae : be;
    d  = hi - lo;
    return (hi > lo) ? d[COORD_BITS-1:0] : '0;
  endfunction

  box_t truth_mem_r [MAX_TRUTH];

  logic [REG_W-1:0]      img_w_r;
  logic [REG_W-1:0]      img_h_r;
  logic [CMD_W-1:0]      cmd_r;
  box_t                  pbox_r;
  box_t                  rd_r;
  status_t               status_r;
  logic [CNT_W-1:0]      count_r;
  logic [SUM_W-1:0]      sum_r;
  logic [IOU_W-1:0]      best_r;
  logic [IDX_W-1:0]      idx_r;
  logic [AREA_W-1:0]     area_p_r;
  logic [AREA_W-1:0]     area_t_r;
  logic [COORD_BITS-1:0] ox_r;
  logic [COORD_BITS-1:0] oy_r;
  logic [AREA_W-1:0]     inter_r;
  logic [UNI_W-1:0]      uni_r;
  logic [REM_W-1:0]      rem_r;
  logic [IOU_W-1:0]      q_r;
  logic [DCNT_W-1:0]     div_cnt_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [IOU_W-1:0]      out_best_r;
  logic [SUM_W-1:0]      out_sum_r;
  logic [CNT_W-1:0]      out_count_r;

  logic [CMP_W-1:0]      x_end;
  logic [CMP_W-1:0]      y_end;
  logic [REM_W-1:0]      rem_sh;
  logic                  rem_ge;
  logic [REM_W-1:0]      rem_nxt;
  logic [SUMX_W-1:0]     sum_ext;
  logic [SUM_W-1:0]      sum_nxt;

  assign x_end = CMP_W'(pbox_r.x) + CMP_W'(pbox_r.w);
  assign y_end = CMP_W'(pbox_r.y) + CMP_W'(pbox_r.h);

  assign rem_sh  = (div_cnt_r == '0) ? rem_r : (rem_r << 1);
  assign rem_ge  = rem_sh >= REM_W'(uni_r);
  assign rem_nxt = rem_ge ? (rem_sh - REM_W'(uni_r)) : rem_sh;

  assign sum_ext = SUMX_W'(sum_r) + SUMX_W'(best_r);
  assign sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_comb begin
    stat.command     = cmd_r;
    stat.box_fits    = (x_end < CMP_W'(img_w_r)) && (y_end < CMP_W'(img_h_r));
    stat.table_full  = count_r >= CNT_MAX;
    stat.table_empty = count_r == '0;
    stat.last_entry  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
    stat.div_last    = div_cnt_r == DCNT_W'(IOU_W - 1);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r     <= IMG_RESET;
      img_h_r     <= IMG_RESET;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_IMG_W) begin
        img_w_r <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_IMG_H) begin
        img_h_r <= cfg_data;
      end
      if (cmd.clear_all) begin
        count_r <= '0;
        sum_r   <= '0;
      end else begin
        if (cmd.store_box) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (cmd.accumulate) begin
          sum_r <= sum_nxt;
        end
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_box) begin
      truth_mem_r[count_r[IDX_W-1:0]] <= pbox_r;
    end
    if (cmd.fetch) begin
      rd_r <= truth_mem_r[idx_r];
    end
  end

  // item payload and per-entry arithmetic
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      cmd_r    <= item_command;
      pbox_r   <= item_box;
      status_r <= ST_OK;
      best_r   <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.start_score) begin
      area_p_r <= AREA_W'(pbox_r.w) * AREA_W'(pbox_r.h);
      idx_r    <= '0;
    end
    if (cmd.overlap) begin
      ox_r     <= span(rd_r.x, rd_r.w, pbox_r.x, pbox_r.w);
      oy_r     <= span(rd_r.y, rd_r.h, pbox_r.y, pbox_r.h);
      area_t_r <= AREA_W'(rd_r.w) * AREA_W'(rd_r.h);
    end
    if (cmd.mult) begin
      inter_r <= AREA_W'(ox_r) * AREA_W'(oy_r);
    end
    if (cmd.div_init) begin
      uni_r     <= UNI_W'(area_t_r) + UNI_W'(area_p_r) - UNI_W'(inter_r);
      rem_r     <= REM_W'(inter_r);
      q_r       <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      q_r       <= {q_r[IOU_W-2:0], rem_ge};
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
    if (cmd.compare) begin
      // zero union scores zero
      if (uni_r != '0 && q_r > best_r) begin
        best_r <= q_r;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.publish) begin
      out_status_r <= status_r;
      out_best_r   <= best_r;
      out_sum_r    <= cmd.accumulate ? sum_nxt : sum_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_best_iou    = out_best_r;
  assign out_iou_sum     = out_sum_r;
  assign out_truth_count = out_count_r;

endmodule

[sv/iou_ctrl.sv]
// controller state machine sequencing one item through the datapath
module iou_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iou_pkg::dp_stat_t  stat,
  output iou_pkg::dp_cmd_t   cmd
);
  import iou_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESULT;
        unique case (stat.command)
          CMD_LOAD: begin
            if (!stat.box_fits) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_OUTSIDE;
            end else if (stat.table_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.store_box = 1'b1;
            end
          end
          CMD_SCORE: begin
            if (!stat.box_fits) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_OUTSIDE;
            end else begin
              cmd.start_score = 1'b1;
              state_nxt       = stat.table_empty ? S_ACCUM : S_FETCH;
            end
          end
          CMD_CLEAR: begin
            cmd.clear_all = 1'b1;
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_OVL;
      end
      S_OVL: begin
        cmd.overlap = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_UNION;
      end
      S_UNION: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = stat.last_entry ? S_ACCUM : S_FETCH;
      end
      S_ACCUM: begin
        cmd.accumulate = 1'b1;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[sv/iou_best_match_total.sv]
// top level of the best-match iou scorer with running total
// Loads up to 16 truth boxes, scores a predicted box against every stored box
// (exclusive extents, IoU = floor(inter * 2^16 / union)), keeps the best and adds
// it to a 24-bit Q8.16 total that saturates. Load, clear, unused and rejected
// items go from accept through decode to the result state; a score item also runs
// a fetch, overlap, multiply and union step per stored box, then the restoring
// divider yielding one quotient bit per cycle, 17 bits per box, and an accumulate
// step. The next item is taken while a result beat waits on the output register.
// Configuration writes are always taken and must only happen while idle.
module iou_best_match_total (
  input logic       clk,
  input logic       rst_n,
  iou_in_if.sink    in_ch,
  iou_out_if.source out_ch,
  iou_cfg_if.sink   cfg_ch
);
  import iou_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  box_t     item_box;
  logic     in_ready;

  assign item_box.x = in_ch.box_x;
  assign item_box.y = in_ch.box_y;
  assign item_box.w = in_ch.box_w;
  assign item_box.h = in_ch.box_h;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  iou_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iou_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .item_command    (in_ch.command),
    .item_box        (item_box),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_best_iou    (out_ch.best_iou),
    .out_iou_sum     (out_ch.iou_sum),
    .out_truth_count (out_ch.truth_count)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.truth_count <= CNT_MAX)
    else $error("truth count beyond table depth");

  a_iou_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.best_iou <= IOU_ONE)
    else $error("best iou above one");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.best_iou == '0)
    else $error("rejected beat carries nonzero iou");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while one is in work");
`endif

endmodule

[dv/iou_best_match_check.sv]
// scoreboard for the best-match iou scorer: predicts each result beat and compares it
`timescale 1ns / 1ps
module iou_best_match_check (
  input  logic clk,
  input  logic rst_n,
  iou_in_if    in_ch,
  iou_out_if   out_ch,
  iou_cfg_if   cfg_ch,
  output int   errors,
  output int   pending
);
  import iou_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [IOU_W-1:0] best_iou;
    logic [SUM_W-1:0] iou_sum;
    logic [CNT_W-1:0] truth_count;
  } iou_result_t;

  localparam longint unsigned SUM_CEIL = (64'd1 << SUM_W) - 64'd1;

  box_t             truth_tab [MAX_TRUTH];
  int unsigned      truth_cnt;
  longint unsigned  iou_total;
  logic [REG_W-1:0] img_w;
  logic [REG_W-1:0] img_h;
  iou_result_t      result_q [$];

  function automatic bit in_image(box_t b);
    return (int'(b.x) + int'(b.w) < int'(img_w)) && (int'(b.y) + int'(b.h) < int'(img_h));
  endfunction

  function automatic longint unsigned span_overlap(int a0, int aw, int b0, int bw);
    int lo;
    int hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + aw < b0 + bw) ? a0 + aw : b0 + bw;
    return (hi > lo) ? longint'(hi - lo) : 64'd0;
  endfunction

  function automatic longint unsigned pair_iou(box_t t, box_t p);
    longint unsigned inter;
    longint unsigned uni;
    inter = span_overlap(int'(t.x), int'(t.w), int'(p.x), int'(p.w)) *
            span_overlap(int'(t.y), int'(t.h), int'(p.y), int'(p.h));
    uni = longint'(t.w) * longint'(t.h) + longint'(p.w) * longint'(p.h) - inter;
    if (uni == 0) begin
      return 64'd0;
    end
    return (inter << FRAC_BITS) / uni;
  endfunction

  function automatic iou_result_t apply_item(logic [CMD_W-1:0] cmd, box_t b);
    iou_result_t     r;
    longint unsigned best;
    longint unsigned s;
    int unsigned     i;
    r.status = ST_OK;
    best = 0;
    case (cmd)
      CMD_LOAD: begin
        if (!in_image(b)) begin
          r.status = ST_OUTSIDE;
        end else if (truth_cnt >= MAX_TRUTH) begin
          r.status = ST_FULL;
        end else begin
          truth_tab[truth_cnt] = b;
          truth_cnt++;
        end
      end
      CMD_SCORE: begin
        if (!in_image(b)) begin
          r.status = ST_OUTSIDE;
        end else begin
          for (i = 0; i < truth_cnt; i++) begin
            s = pair_iou(truth_tab[i], b);
            if (s > best) begin
              best = s;
            end
          end
          iou_total += best;
          if (iou_total > SUM_CEIL) begin
            iou_total = SUM_CEIL;
          end
        end
      end
      CMD_CLEAR: begin
        truth_cnt = 0;
        iou_total = 0;
      end
      default: begin
      end
    endcase
    r.best_iou    = best[IOU_W-1:0];
    r.iou_sum     = iou_total[SUM_W-1:0];
    r.truth_count = truth_cnt[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    iou_result_t want;
    box_t        item;
    int          bad;
    bad = 0;
    if (!rst_n) begin
      truth_cnt = 0;
      iou_total = 0;
      img_w = IMG_RESET;
      img_h = IMG_RESET;
      result_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_IMG_W) begin
          img_w = cfg_ch.data;
        end else if (cfg_ch.index == CFG_IMG_H) begin
          img_h = cfg_ch.data;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          bad++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            bad++;
          end
          if (out_ch.best_iou !== want.best_iou) begin
            $error("best_iou: expected %0d, actual %0d", want.best_iou, out_ch.best_iou);
            bad++;
          end
          if (out_ch.iou_sum !== want.iou_sum) begin
            $error("iou_sum: expected %0d, actual %0d", want.iou_sum, out_ch.iou_sum);
            bad++;
          end
          if (out_ch.truth_count !== want.truth_count) begin
            $error("truth_count: expected %0d, actual %0d", want.truth_count,
                   out_ch.truth_count);
            bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item = {in_ch.box_x, in_ch.box_y, in_ch.box_w, in_ch.box_h};
        result_q.push_back(apply_item(in_ch.command, item));
      end
      errors  <= errors + bad;
      pending <= result_q.size();
    end
  end

endmodule

[dv/iou_best_match_total_test.sv]
// testbench top for the best-match iou scorer: stimulus, flow control and verdict
`timescale 1ns / 1ps
module iou_best_match_total_test;
  import iou_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  logic             clk;
  logic             rst_n;
  int               errors;
  int               pending;
  bit               calm;
  logic [REG_W-1:0] img_w;
  logic [REG_W-1:0] img_h;
  box_t             loaded_q [$];

  iou_in_if  in_ch ();
  iou_out_if out_ch ();
  iou_cfg_if cfg_ch ();

  iou_best_match_total dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  iou_best_match_check match_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    int roll;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          out_ch.ready <= 1'b1;
          hold = $urandom_range(0, 15);
        end else if (roll < 93) begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ch.ready <= 1'b0;
          hold = $urandom_range(10, 60);
        end
      end
    end
  end

  function automatic bit fits_image(box_t b);
    return (int'(b.x) + int'(b.w) < int'(img_w)) && (int'(b.y) + int'(b.h) < int'(img_h));
  endfunction

  function automatic box_t box_at(int x, int y, int w, int h);
    box_t b;
    b.x = x[COORD_BITS-1:0];
    b.y = y[COORD_BITS-1:0];
    b.w = w[COORD_BITS-1:0];
    b.h = h[COORD_BITS-1:0];
    return b;
  endfunction

  function automatic box_t noise_box();
    return box_at($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endfunction

  function automatic void pick_span(logic [REG_W-1:0] lim, output int pos, output int len);
    int top_end;
    int cap;
    if (lim == 0) begin
      pos = $urandom_range(0, COORD_MAX);
      len = $urandom_range(0, COORD_MAX);
      return;
    end
    top_end = int'(lim) - 1;
    cap = ($urandom_range(0, 1) == 1) ? COORD_MAX : 63;
    if (cap > top_end) begin
      cap = top_end;
    end
    len = $urandom_range(0, cap);
    cap = top_end - len;
    if (cap > COORD_MAX) begin
      cap = COORD_MAX;
    end
    pos = $urandom_range(0, cap);
  endfunction

  function automatic box_t inside_box();
    int x;
    int y;
    int w;
    int h;
    pick_span(img_w, x, w);
    pick_span(img_h, y, h);
    return box_at(x, y, w, h);
  endfunction

  function automatic box_t near_copy(box_t src);
    box_t b;
    int   j;
    b = src;
    j = $urandom_range(0, 3);
    if (j > 0) begin
      b = box_at(int'(src.x) + $urandom_range(0, 2 * j) - j,
                 int'(src.y) + $urandom_range(0, 2 * j) - j,
                 int'(src.w) + $urandom_range(0, 2 * j) - j,
                 int'(src.h) + $urandom_range(0, 2 * j) - j);
      if (!fits_image(b)) begin
        b = src;
      end
    end
    return b;
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, box_t b);
    int gap;
    gap = 0;
    if (!calm) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.box_x   <= b.x;
    in_ch.box_y   <= b.y;
    in_ch.box_w   <= b.w;
    in_ch.box_h   <= b.h;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_CLEAR) begin
      loaded_q.delete();
    end else if (cmd == CMD_LOAD && fits_image(b) && loaded_q.size() < MAX_TRUTH) begin
      loaded_q.push_back(b);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    drain();
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_IMG_W) begin
      img_w = value;
    end else begin
      img_h = value;
    end
  endtask

  task automatic random_item(bit saturate);
    int roll;
    roll = $urandom_range(0, 99);
    if (saturate) begin
      if (loaded_q.size() == 0) begin
        send_item(CMD_LOAD, inside_box());
      end else if (roll < 98) begin
        send_item(CMD_SCORE, loaded_q[0]);
      end else begin
        send_item(CMD_SCORE, inside_box());
      end
    end else if (roll < 8) begin
      send_item(CMD_W'($urandom_range(0, 3)), noise_box());
    end else if (roll < 12) begin
      send_item(CMD_CLEAR, noise_box());
    end else if (roll < 40) begin
      send_item(CMD_LOAD, inside_box());
    end else if (loaded_q.size() > 0 && roll < 80) begin
      send_item(CMD_SCORE, near_copy(loaded_q[$urandom_range(0, loaded_q.size() - 1)]));
    end else begin
      send_item(CMD_SCORE, inside_box());
    end
    if ($urandom_range(0, 49) == 0) begin
      drain();
    end
  endtask

  task automatic run_phase(int w, int h, int count, bit quiet, bit saturate);
    write_cfg(CFG_IMG_W, REG_W'(w));
    write_cfg(CFG_IMG_H, REG_W'(h));
    calm = quiet;
    if (saturate) begin
      send_item(CMD_CLEAR, box_at(0, 0, 0, 0));
    end
    repeat (count) random_item(saturate);
  endtask

  initial begin
    int i;
    calm = 1'b0;
    img_w = IMG_RESET;
    img_h = IMG_RESET;
    rst_n = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_LOAD;
    in_ch.box_x   = '0;
    in_ch.box_y   = '0;
    in_ch.box_w   = '0;
    in_ch.box_h   = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_IMG_W;
    cfg_ch.data   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, exact, partial and zero-area matches
    send_item(CMD_SCORE, box_at(0, 0, 10, 10));
    send_item(CMD_LOAD, box_at(100, 100, 50, 50));
    send_item(CMD_SCORE, box_at(100, 100, 50, 50));
    send_item(CMD_SCORE, box_at(125, 100, 50, 50));
    send_item(CMD_LOAD, box_at(0, 0, 0, 0));
    send_item(CMD_SCORE, box_at(0, 0, 0, 0));
    send_item(CMD_LOAD, box_at(COORD_MAX, 0, 0, 0));
    send_item(CMD_LOAD, box_at(0, 0, COORD_MAX, COORD_MAX));
    send_item(CMD_SCORE, box_at(0, 0, COORD_MAX, COORD_MAX));
    // right and bottom edges touch the image border
    send_item(CMD_LOAD, box_at(COORD_MAX, COORD_MAX, 1, 0));
    send_item(CMD_SCORE, box_at(0, COORD_MAX, 0, 1));
    for (i = 0; i < 12; i++) begin
      send_item(CMD_LOAD, box_at(i * 300, i * 200, 150 + i, 90 + i));
    end
    send_item(CMD_LOAD, box_at(10, 10, 5, 5));
    // outside status wins over full table
    send_item(CMD_LOAD, box_at(COORD_MAX, 0, 1, 0));
    send_item(CMD_SCORE, box_at(300, 200, 151, 91));
    send_item(CMD_UNUSED, box_at(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(CMD_CLEAR, box_at(0, 0, 0, 0));
    send_item(CMD_SCORE, box_at(100, 100, 50, 50));

    run_phase(4096, 4096, 80, 1'b0, 1'b0);
    run_phase(640, 480, 80, 1'b1, 1'b0);
    run_phase(0, 4096, 20, 1'b0, 1'b0);
    run_phase(4096, 0, 15, 1'b0, 1'b0);
    run_phase(1, 1, 20, 1'b0, 1'b0);
    run_phase(8191, 8191, 60, 1'b0, 1'b0);
    run_phase(32, 32, 280, 1'b0, 1'b1);

    calm = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
